// File: design/bfha_pkg.sv
package bfha_pkg;

  localparam int HEAP_BYTES      = 4096;
  localparam int MIN_SPLIT_BYTES = 32;
  localparam int HEADER_BYTES    = 8;
  localparam int HEAP_WORDS      = HEAP_BYTES / 4;
  localparam int SLOT_DEPTH      = HEAP_BYTES / MIN_SPLIT_BYTES;
  localparam int WORD_AW         = $clog2(HEAP_WORDS);
  localparam int SLOT_AW         = $clog2(SLOT_DEPTH);
  localparam int BYTES_W         = $clog2(HEAP_BYTES) + 1;
  localparam int COUNT_W         = SLOT_AW + 1;
  localparam int ADV_W           = WORD_AW + 1;
  localparam int NEED_W          = 14;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FIT  = 2'd1;
  localparam logic [1:0] ST_ZERO    = 2'd2;
  localparam logic [1:0] ST_BAD_BLK = 2'd3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef struct packed {
    logic        command;
    logic [12:0] request_bytes;
    logic [11:0] block_offset;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] payload_offset;
  } rsp_t;

  // per heap word: header present, chunk free, chunk size in bytes
  typedef struct packed {
    logic               hv;
    logic               cf;
    logic [BYTES_W-1:0] bytes;
  } word_t;

endpackage

// File: design/bfha_ram.sv
module bfha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/best_fit_heap_allocator_core.sv
// Best-fit heap allocator over a 4096-byte heap of chunks with 8-byte headers.
// Command channel (cmd_valid/cmd_stall/cmd): allocate or free one block.
// Response channel (rsp_valid/rsp_stall/rsp): one status/offset item per
// command, in command order.
// Each command runs on a small sequencer around one word memory (headers)
// and one slot memory (address-sorted free list), each with one read and one write port.
// Allocate: scans every free-list slot, then shifts the later slots down
// when a chunk is taken whole.
// Free: walks the chunks from the heap start to the block, then searches
// the list and moves slots.
// cmd_stall is high while a command runs; one command at a time.
// The response sits in an output register; a new command is taken while it
// waits, but finishing that command waits until the response is taken.
// After reset a clearing pass writes all 1024 header words,
// with cmd_stall high throughout.
// rsp holds steady while rsp_valid is high and rsp_stall is high.
module best_fit_heap_allocator_core
  import bfha_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_A_RS   = 5'd2;
  localparam logic [4:0] S_A_RW   = 5'd3;
  localparam logic [4:0] S_A_CMP  = 5'd4;
  localparam logic [4:0] S_A_END  = 5'd5;
  localparam logic [4:0] S_A_SPL  = 5'd6;
  localparam logic [4:0] S_A_SLT  = 5'd7;
  localparam logic [4:0] S_SH_DN  = 5'd8;
  localparam logic [4:0] S_SH_DN2 = 5'd9;
  localparam logic [4:0] S_F_RD   = 5'd10;
  localparam logic [4:0] S_F_CHK  = 5'd11;
  localparam logic [4:0] S_F_WR   = 5'd12;
  localparam logic [4:0] S_F_WA   = 5'd13;
  localparam logic [4:0] S_F_NX   = 5'd14;
  localparam logic [4:0] S_F_NXD  = 5'd15;
  localparam logic [4:0] S_F_DEC  = 5'd16;
  localparam logic [4:0] S_F_B1   = 5'd17;
  localparam logic [4:0] S_F_B2   = 5'd18;
  localparam logic [4:0] S_F_P1   = 5'd19;
  localparam logic [4:0] S_F_N1   = 5'd20;
  localparam logic [4:0] S_SR     = 5'd21;
  localparam logic [4:0] S_SR_CMP = 5'd22;
  localparam logic [4:0] S_SR_END = 5'd23;
  localparam logic [4:0] S_SH_UP  = 5'd24;
  localparam logic [4:0] S_SH_UP2 = 5'd25;
  localparam logic [4:0] S_DONE   = 5'd26;

  localparam logic [1:0] M_DROP = 2'd0;
  localparam logic [1:0] M_REPL = 2'd1;
  localparam logic [1:0] M_INS  = 2'd2;

  logic [4:0]         state;
  logic [WORD_AW-1:0] clr_cnt;
  logic [NEED_W-1:0]  need;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] idx;
  logic [COUNT_W-1:0] jdx;
  logic               found;
  logic [COUNT_W-1:0] best_idx;
  logic [WORD_AW-1:0] best_w;
  logic [BYTES_W-1:0] best_sz;
  logic [WORD_AW-1:0] scan_w;
  logic [WORD_AW-1:0] nw;
  logic [WORD_AW-1:0] tw;
  logic [WORD_AW-1:0] cur;
  logic [WORD_AW-1:0] prev;
  logic               has_prev;
  logic               prev_free;
  logic [BYTES_W-1:0] prev_bytes;
  logic [BYTES_W-1:0] bw;
  logic [WORD_AW-1:0] nxt;
  logic               next_free;
  logic [BYTES_W-1:0] bn;
  logic [WORD_AW-1:0] target;
  logic [1:0]         mode;
  logic [1:0]         res_status;
  logic [11:0]        res_off;

  logic               w_we;
  logic [WORD_AW-1:0] w_waddr;
  word_t              w_wdata;
  logic [WORD_AW-1:0] w_raddr;
  word_t              w_rdata;
  logic               s_we;
  logic [SLOT_AW-1:0] s_waddr;
  logic [WORD_AW-1:0] s_wdata;
  logic [SLOT_AW-1:0] s_raddr;
  logic [WORD_AW-1:0] s_rdata;

  logic [NEED_W-1:0]  need_in;
  logic [ADV_W-1:0]   adv;
  logic [ADV_W-1:0]   walk_sum;
  logic [ADV_W+1:0]   nw_sum;
  logic [ADV_W-1:0]   nxt_sum;
  logic               split;
  logic               pf;

  bfha_ram #(.WIDTH($bits(word_t)), .DEPTH(HEAP_WORDS)) u_words (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  bfha_ram #(.WIDTH(WORD_AW), .DEPTH(SLOT_DEPTH)) u_slots (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  assign need_in  = ((NEED_W'(cmd.request_bytes) + NEED_W'(3)) & ~NEED_W'(3))
                    + NEED_W'(HEADER_BYTES);
  assign adv      = ADV_W'(w_rdata.bytes >> 2);
  assign walk_sum = ADV_W'(cur) + adv;
  assign nw_sum   = (ADV_W+2)'(best_w) + (ADV_W+2)'(need >> 2);
  assign nxt_sum  = ADV_W'(tw) + ADV_W'(bw >> 2);
  assign split    = (NEED_W+1)'(best_sz) > (NEED_W+1)'(need) + (NEED_W+1)'(MIN_SPLIT_BYTES);
  assign pf       = has_prev & prev_free;
  assign cmd_stall = (state != S_IDLE);

  // memory ports
  always_comb begin
    w_we    = 1'b0;
    w_waddr = tw;
    w_wdata = '0;
    w_raddr = tw;
    s_we    = 1'b0;
    s_waddr = idx[SLOT_AW-1:0];
    s_wdata = tw;
    s_raddr = idx[SLOT_AW-1:0];
    case (state)
      S_CLR: begin
        w_we    = 1'b1;
        w_waddr = clr_cnt;
        if (clr_cnt == '0) begin
          w_wdata = '{hv: 1'b1, cf: 1'b1, bytes: BYTES_W'(HEAP_BYTES)};
        end
        s_we    = (clr_cnt == '0);
        s_waddr = '0;
        s_wdata = '0;
      end
      S_A_RW:  w_raddr = s_rdata;
      S_A_END: begin
        w_we    = found;
        w_waddr = best_w;
        w_wdata = '{hv: 1'b1, cf: 1'b0, bytes: split ? BYTES_W'(need) : best_sz};
      end
      S_A_SPL: begin
        w_we    = (nw_sum < (ADV_W+2)'(HEAP_WORDS));
        w_waddr = WORD_AW'(nw_sum);
        w_wdata = '{hv: 1'b1, cf: 1'b1, bytes: BYTES_W'(best_sz - BYTES_W'(need))};
      end
      S_A_SLT: begin
        s_we    = 1'b1;
        s_waddr = best_idx[SLOT_AW-1:0];
        s_wdata = nw;
      end
      S_SH_DN:  s_raddr = SLOT_AW'(idx + COUNT_W'(1));
      S_SH_DN2: begin
        s_we    = 1'b1;
        s_waddr = idx[SLOT_AW-1:0];
        s_wdata = s_rdata;
      end
      S_F_WR:  w_raddr = cur;
      S_F_NX:  w_raddr = WORD_AW'(nxt_sum);
      S_F_DEC: begin
        if (pf && next_free) begin
          w_we    = 1'b1;
          w_waddr = prev;
          w_wdata = '{hv: 1'b1, cf: 1'b1, bytes: BYTES_W'(prev_bytes + bw + bn)};
        end else if (pf) begin
          w_we    = 1'b1;
          w_waddr = prev;
          w_wdata = '{hv: 1'b1, cf: 1'b1, bytes: BYTES_W'(prev_bytes + bw)};
        end else if (next_free) begin
          w_we    = 1'b1;
          w_wdata = '{hv: 1'b1, cf: 1'b1, bytes: BYTES_W'(bw + bn)};
        end else if (count < COUNT_W'(SLOT_DEPTH)) begin
          w_we    = 1'b1;
          w_wdata = '{hv: 1'b1, cf: 1'b1, bytes: bw};
        end
      end
      S_F_B1, S_F_P1: begin
        w_we    = 1'b1;
        w_wdata = '{hv: 1'b0, cf: 1'b0, bytes: bw};
      end
      S_F_B2, S_F_N1: begin
        w_we    = 1'b1;
        w_waddr = nxt;
        w_wdata = '{hv: 1'b0, cf: 1'b1, bytes: bn};
      end
      S_SR_END: begin
        s_we    = (mode == M_REPL) && (idx != count);
        s_waddr = idx[SLOT_AW-1:0];
        s_wdata = tw;
      end
      S_SH_UP: begin
        s_we    = (jdx == idx);
        s_waddr = idx[SLOT_AW-1:0];
        s_wdata = tw;
        s_raddr = SLOT_AW'(jdx - COUNT_W'(1));
      end
      S_SH_UP2: begin
        s_we    = 1'b1;
        s_waddr = jdx[SLOT_AW-1:0];
        s_wdata = s_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_cnt   <= '0;
      count     <= COUNT_W'(1);
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + WORD_AW'(1);
          if (clr_cnt == WORD_AW'(HEAP_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          res_status <= ST_OK;
          res_off    <= '0;
          idx        <= '0;
          found      <= 1'b0;
          has_prev   <= 1'b0;
          prev_free  <= 1'b0;
          next_free  <= 1'b0;
          cur        <= '0;
          need       <= need_in;
          tw         <= WORD_AW'((cmd.block_offset - 12'(HEADER_BYTES)) >> 2);
          if (cmd_valid) begin
            if (cmd.command == CMD_ALLOC) begin
              if (cmd.request_bytes == '0) begin
                res_status <= ST_ZERO;
                state      <= S_DONE;
              end else begin
                state <= S_A_RS;
              end
            end else if (cmd.block_offset < 12'(HEADER_BYTES) ||
                         cmd.block_offset[1:0] != 2'b00) begin
              res_status <= ST_BAD_BLK;
              state      <= S_DONE;
            end else begin
              state <= S_F_RD;
            end
          end
        end
        // best-fit scan over the free list
        S_A_RS:  state <= (idx == count) ? S_A_END : S_A_RW;
        S_A_RW: begin
          scan_w <= s_rdata;
          state  <= S_A_CMP;
        end
        S_A_CMP: begin
          if (NEED_W'(w_rdata.bytes) >= need && (!found || w_rdata.bytes < best_sz)) begin
            found    <= 1'b1;
            best_idx <= idx;
            best_w   <= scan_w;
            best_sz  <= w_rdata.bytes;
          end
          idx   <= idx + COUNT_W'(1);
          state <= S_A_RS;
        end
        S_A_END: begin
          if (!found) begin
            res_status <= ST_NO_FIT;
            state      <= S_DONE;
          end else begin
            res_off <= 12'({best_w, 2'b00} + (WORD_AW+2)'(HEADER_BYTES));
            idx     <= best_idx;
            state   <= split ? S_A_SPL : S_SH_DN;
          end
        end
        S_A_SPL: begin
          nw    <= WORD_AW'(nw_sum);
          state <= (nw_sum < (ADV_W+2)'(HEAP_WORDS)) ? S_A_SLT : S_DONE;
        end
        S_A_SLT: state <= S_DONE;
        // remove slot idx, moving later slots down
        S_SH_DN: begin
          if (idx + COUNT_W'(1) >= count) begin
            count <= count - COUNT_W'(1);
            state <= S_DONE;
          end else begin
            state <= S_SH_DN2;
          end
        end
        S_SH_DN2: begin
          idx   <= idx + COUNT_W'(1);
          state <= S_SH_DN;
        end
        S_F_RD: state <= S_F_CHK;
        S_F_CHK: begin
          bw <= w_rdata.bytes;
          if (!w_rdata.hv || w_rdata.cf) begin
            res_status <= ST_BAD_BLK;
            state      <= S_DONE;
          end else begin
            state <= S_F_WR;
          end
        end
        // walk the chunk chain from the heap start up to the block
        S_F_WR: begin
          if (cur == tw) begin
            state <= S_F_NX;
          end else if (cur > tw) begin
            res_status <= ST_BAD_BLK;
            state      <= S_DONE;
          end else begin
            state <= S_F_WA;
          end
        end
        S_F_WA: begin
          if (adv == '0 || walk_sum >= ADV_W'(HEAP_WORDS)) begin
            res_status <= ST_BAD_BLK;
            state      <= S_DONE;
          end else begin
            prev       <= cur;
            has_prev   <= 1'b1;
            prev_free  <= w_rdata.cf;
            prev_bytes <= w_rdata.bytes;
            cur        <= WORD_AW'(walk_sum);
            state      <= S_F_WR;
          end
        end
        S_F_NX: begin
          nxt   <= WORD_AW'(nxt_sum);
          state <= (nxt_sum < ADV_W'(HEAP_WORDS)) ? S_F_NXD : S_F_DEC;
        end
        S_F_NXD: begin
          next_free <= w_rdata.hv & w_rdata.cf;
          bn        <= w_rdata.bytes;
          state     <= S_F_DEC;
        end
        S_F_DEC: begin
          idx <= '0;
          if (pf && next_free) begin
            state <= S_F_B1;
          end else if (pf) begin
            state <= S_F_P1;
          end else if (next_free) begin
            state <= S_F_N1;
          end else if (count >= COUNT_W'(SLOT_DEPTH)) begin
            res_status <= ST_NO_FIT;
            state      <= S_DONE;
          end else begin
            target <= tw;
            mode   <= M_INS;
            state  <= S_SR;
          end
        end
        S_F_B1: state <= S_F_B2;
        S_F_B2: begin
          target <= nxt;
          mode   <= M_DROP;
          state  <= S_SR;
        end
        S_F_P1: state <= S_DONE;
        S_F_N1: begin
          target <= nxt;
          mode   <= M_REPL;
          state  <= S_SR;
        end
        // list search: exact match, or first slot at or above for insertion
        S_SR:  state <= (idx == count) ? S_SR_END : S_SR_CMP;
        S_SR_CMP: begin
          if ((mode == M_INS) ? (s_rdata >= target) : (s_rdata == target)) begin
            state <= S_SR_END;
          end else begin
            idx   <= idx + COUNT_W'(1);
            state <= S_SR;
          end
        end
        S_SR_END: begin
          jdx <= count;
          case (mode)
            M_DROP:  state <= (idx == count) ? S_DONE : S_SH_DN;
            M_INS:   state <= S_SH_UP;
            default: state <= S_DONE;
          endcase
        end
        S_SH_UP: begin
          if (jdx == idx) begin
            count <= count + COUNT_W'(1);
            state <= S_DONE;
          end else begin
            state <= S_SH_UP2;
          end
        end
        S_SH_UP2: begin
          jdx   <= jdx - COUNT_W'(1);
          state <= S_SH_UP;
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!rsp_valid || !rsp_stall)) begin
      rsp.status         <= res_status;
      rsp.payload_offset <= (res_status == ST_OK) ? res_off : '0;
    end
  end

endmodule

// File: design/bfha_checker.sv
module bfha_checker
  import bfha_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic cmd_valid,
  input logic cmd_stall,
  input cmd_t cmd,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("block took a command without going busy");

  a_err_zero_offset: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.payload_offset == '0)
    else $error("error response with nonzero offset");

  a_offset_aligned: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.payload_offset[1:0] == 2'b00)
    else $error("payload offset not word aligned");

  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) |-> cmd_stall && !rsp_valid)
    else $error("block ready before clearing pass");

endmodule

bind best_fit_heap_allocator_core bfha_checker u_bfha_checker (.*);

// File: tb/heap_alloc_checker.sv
module heap_alloc_checker
  import bfha_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  logic cmd_stall,
  input  cmd_t cmd,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic             hdr_ok [HEAP_WORDS];
  logic             is_free [HEAP_WORDS];
  int unsigned      size_of [HEAP_WORDS];
  int unsigned      free_list [SLOT_DEPTH];
  int unsigned      n_free;
  rsp_t             want_q [$];

  function automatic void heap_clear();
    for (int i = 0; i < HEAP_WORDS; i++) begin
      hdr_ok[i] = 0;
      is_free[i] = 0;
      size_of[i] = 0;
    end
    for (int i = 0; i < SLOT_DEPTH; i++) free_list[i] = 0;
    hdr_ok[0] = 1;
    is_free[0] = 1;
    size_of[0] = HEAP_BYTES;
    n_free = 1;
  endfunction

  function automatic int unsigned find_slot(int unsigned w);
    for (int unsigned i = 0; i < n_free; i++)
      if (free_list[i] == w) return i;
    return n_free;
  endfunction

  function automatic void remove_slot(int unsigned idx);
    if (idx >= n_free) return;
    for (int unsigned i = idx; i + 1 < n_free; i++) free_list[i] = free_list[i+1];
    n_free--;
  endfunction

  function automatic rsp_t do_allocate(int unsigned req);
    rsp_t r;
    int unsigned need, best, best_sz, w, orig, nw;
    bit found;
    r = '0;
    found = 0;
    best = 0;
    best_sz = 0;
    if (req == 0) begin
      r.status = ST_ZERO;
      return r;
    end
    need = ((req + 3) & ~32'd3) + HEADER_BYTES;
    for (int unsigned i = 0; i < n_free; i++) begin
      if (size_of[free_list[i]] >= need && (!found || size_of[free_list[i]] < best_sz)) begin
        found = 1;
        best = i;
        best_sz = size_of[free_list[i]];
      end
    end
    if (!found) begin
      r.status = ST_NO_FIT;
      return r;
    end
    w = free_list[best];
    orig = size_of[w];
    is_free[w] = 0;
    if (orig <= need + MIN_SPLIT_BYTES) begin
      remove_slot(best);
    end else begin
      nw = w + need / 4;
      size_of[w] = need;
      if (nw < HEAP_WORDS) begin
        hdr_ok[nw] = 1;
        is_free[nw] = 1;
        size_of[nw] = orig - need;
        free_list[best] = nw;
      end
    end
    r.status = ST_OK;
    r.payload_offset = 12'(w * 4 + HEADER_BYTES);
    return r;
  endfunction

  function automatic rsp_t do_release(int unsigned off);
    rsp_t r;
    int unsigned w, cur, prv, nxt, adv, i;
    bit has_prv, has_nxt, prv_free, nxt_free;
    r = '0;
    r.status = ST_BAD_BLK;
    prv = 0;
    has_prv = 0;
    if (off < HEADER_BYTES || (off & 3) != 0) return r;
    w = (off - HEADER_BYTES) / 4;
    if (w >= HEAP_WORDS || !hdr_ok[w] || is_free[w]) return r;
    cur = 0;
    for (int steps = 0; cur != w && steps < HEAP_WORDS; steps++) begin
      adv = size_of[cur] / 4;
      if (adv == 0 || cur + adv >= HEAP_WORDS) return r;
      prv = cur;
      has_prv = 1;
      cur += adv;
    end
    if (cur != w) return r;
    nxt = w + size_of[w] / 4;
    has_nxt = nxt < HEAP_WORDS && hdr_ok[nxt];
    prv_free = has_prv && is_free[prv];
    nxt_free = has_nxt && is_free[nxt];
    if (prv_free && nxt_free) begin
      size_of[prv] += size_of[w] + size_of[nxt];
      remove_slot(find_slot(nxt));
      hdr_ok[w] = 0;
      hdr_ok[nxt] = 0;
    end else if (prv_free) begin
      size_of[prv] += size_of[w];
      hdr_ok[w] = 0;
    end else if (nxt_free) begin
      i = find_slot(nxt);
      if (i < n_free) free_list[i] = w;
      size_of[w] += size_of[nxt];
      is_free[w] = 1;
      hdr_ok[nxt] = 0;
    end else begin
      if (n_free >= SLOT_DEPTH) begin
        r.status = ST_NO_FIT;
        return r;
      end
      for (i = 0; i < n_free && free_list[i] < w; i++) ;
      for (int unsigned j = n_free; j > i; j--) free_list[j] = free_list[j-1];
      free_list[i] = w;
      n_free++;
      is_free[w] = 1;
    end
    r.status = ST_OK;
    return r;
  endfunction

  initial heap_clear();
  initial fail_count = 0;
  assign pending = want_q.size();

  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (cmd_valid && !cmd_stall) begin
        if (cmd.command == CMD_ALLOC) want_q.push_back(do_allocate(cmd.request_bytes));
        else want_q.push_back(do_release(cmd.block_offset));
      end
      if (rsp_valid && !rsp_stall) begin
        if (want_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected response %h", rsp);
        end else begin
          want = want_q.pop_front();
          if (rsp.status !== want.status || rsp.payload_offset !== want.payload_offset) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: status exp %0d got %0d, offset exp %0d got %0d",
                       want.status, rsp.status, want.payload_offset, rsp.payload_offset);
          end
        end
      end
    end
  end
endmodule

// File: tb/tb_best_fit_heap_allocator_core.sv
module tb_best_fit_heap_allocator_core;
  import bfha_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 200000;

  logic clk = 0;
  logic rst = 1;
  logic cmd_valid = 0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_stall = 0;
  rsp_t rsp;
  int   fail_count, pending;
  int   idle_cycles = 0;
  bit   hold_off = 0;
  bit   stim_done = 0;
  logic [11:0] live_q [$];

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  best_fit_heap_allocator_core uut (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp));

  heap_alloc_checker chk (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .fail_count(fail_count), .pending(pending));

  // grab offsets of good allocations so frees mostly name live blocks
  always @(posedge clk)
    if (!rst && rsp_valid && !rsp_stall && rsp.status == ST_OK && rsp.payload_offset != 0)
      live_q.push_back(rsp.payload_offset);

  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("tb_best_fit_heap_allocator_core failed");
      $finish;
    end
  end

  // receiver: own stall pattern, plus one long hold-off
  initial begin
    int mode;
    @(negedge clk);
    while (!stim_done) begin
      @(negedge clk);
      if (hold_off) rsp_stall <= 1;
      else begin
        mode = int'(($time / 4000) % 3);
        if (mode == 0) rsp_stall <= 0;
        else if (mode == 1) rsp_stall <= ($urandom_range(0, 3) == 0);
        else rsp_stall <= ($urandom_range(0, 1) == 0);
      end
    end
    rsp_stall <= 0;
  end

  initial begin
    int hold_cnt;
    wait (!rst);
    repeat (3000) @(negedge clk);
    hold_off = 1;
    hold_cnt = 0;
    while (hold_cnt < 3000) begin
      @(negedge clk);
      hold_cnt++;
    end
    hold_off = 0;
  end

  task automatic send(input logic c, input logic [12:0] req, input logic [11:0] off);
    cmd_valid <= 1;
    cmd.command <= c;
    cmd.request_bytes <= req;
    cmd.block_offset <= off;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic gap();
    cmd_valid <= 0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  task automatic free_live();
    int k;
    logic [11:0] o;
    if (live_q.size() == 0) send(CMD_FREE, 13'($urandom), 12'($urandom));
    else begin
      k = $urandom_range(0, live_q.size() - 1);
      o = live_q[k];
      live_q.delete(k);
      send(CMD_FREE, 13'($urandom), o);
    end
  endtask

  initial begin
    int r, burst, wait_cnt;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed
    send(CMD_ALLOC, 13'd0, 12'hfff);
    send(CMD_ALLOC, 13'd4096, 12'd0);
    send(CMD_ALLOC, 13'd4088, 12'd0);
    send(CMD_FREE, 13'h1fff, 12'd8);
    send(CMD_FREE, 13'd0, 12'd8);
    send(CMD_ALLOC, 13'h1fff, 12'd0);
    send(CMD_ALLOC, 13'd1, 12'hfff);
    send(CMD_ALLOC, 13'd3, 12'd0);
    send(CMD_ALLOC, 13'd40, 12'd0);
    send(CMD_ALLOC, 13'd5, 12'd0);
    send(CMD_FREE, 13'd0, 12'd4);
    send(CMD_FREE, 13'd0, 12'd10);
    send(CMD_FREE, 13'd0, 12'hffc);
    send(CMD_FREE, 13'd0, 12'hfff);
    send(CMD_FREE, 13'd0, 12'd0);
    send(CMD_FREE, 13'd0, 12'd24);
    send(CMD_FREE, 13'd0, 12'd8);
    send(CMD_FREE, 13'd0, 12'd16);
    send(CMD_ALLOC, 13'd4000, 12'd0);
    send(CMD_FREE, 13'd0, 12'd8);
    // allocate many small blocks from the heap
    for (int i = 0; i < 120; i++) send(CMD_ALLOC, 13'd1, 12'($urandom));
    // free at a 32-byte offset stride; the blocks that match join the free list
    for (int i = 0; i < 120; i += 2) send(CMD_FREE, 13'($urandom), 12'(8 + i * 16));
    send(CMD_FREE, 13'd0, 12'd8);
    live_q.delete();
    for (int i = 0; i < 128; i++) send(CMD_FREE, 13'd0, 12'(8 + i * 16));
    // random
    for (int n = 0; n < 1100;) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst; b++, n++) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          if ($urandom_range(0, 9) == 0) send(CMD_ALLOC, 13'($urandom), 12'($urandom));
          else send(CMD_ALLOC, 13'($urandom_range(1, 300)), 12'($urandom));
        end else if (r < 90) free_live();
        else send(CMD_FREE, 13'($urandom), 12'($urandom));
      end
      gap();
    end
    cmd_valid <= 0;
    stim_done = 1;
    wait_cnt = 0;
    while (pending != 0 && wait_cnt < WATCHDOG) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (2000) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("tb_best_fit_heap_allocator_core passed");
    else $display("tb_best_fit_heap_allocator_core failed");
    $finish;
  end
endmodule

// File: sim.f
design/bfha_pkg.sv
design/bfha_ram.sv
design/best_fit_heap_allocator_core.sv
design/bfha_checker.sv
tb/heap_alloc_checker.sv
tb/tb_best_fit_heap_allocator_core.sv
